// File: rtl/tfcl_pkg.sv
// tfcl_pkg: types, codes and constants of the two-factor code lock controller
// no dependencies; used by tfcl_in_if, tfcl_core and the top level
package tfcl_pkg;

  localparam int unsigned CodeLength = 4;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CodeWidth  = CodeLength * CharWidth;
  localparam int unsigned CountWidth = $clog2(CodeLength);

  localparam logic [CountWidth-1:0] COUNT_LAST = CountWidth'(CodeLength - 1);

  localparam logic [CodeWidth-1:0] STORED_CODE_RESET   = 32'h3433_3231;
  localparam logic [CodeWidth-1:0] FACTOR_CODE_RESET   = 32'h3132_3334;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FACTOR = 2'd1;
  localparam logic [1:0] OP_BUTTON = 2'd2;

  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_9    = 8'h39;
  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_D    = 8'h44;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;

  typedef enum logic [2:0] {
    MODE_ENTER      = 3'd0,
    MODE_FACTOR     = 3'd1,
    MODE_UNLOCKED   = 3'd2,
    MODE_FACTOR_CHG = 3'd3,
    MODE_NEW        = 3'd4,
    MODE_CONFIRM    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_NONE   = 2'd0,
    MOTOR_LOCK   = 2'd1,
    MOTOR_UNLOCK = 2'd2
  } motor_t;

  typedef enum logic [3:0] {
    MSG_NONE       = 4'd0,
    MSG_ENTER_CODE = 4'd1,
    MSG_WRONG_CODE = 4'd2,
    MSG_USE_FACTOR = 4'd3,
    MSG_UNLOCKED   = 4'd4,
    MSG_ENTER_NEW  = 4'd5,
    MSG_CONFIRM    = 4'd6,
    MSG_MISMATCH   = 4'd7,
    MSG_CODE_SET   = 4'd8
  } msg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [CharWidth-1:0] key;
    logic [CodeWidth-1:0] factor;
  } item_t;

  typedef struct packed {
    mode_t                 mode;
    logic [CountWidth-1:0] count;
    logic [CodeWidth-1:0]  entry;
    logic [CodeWidth-1:0]  pending;
    logic [CodeWidth-1:0]  stored;
  } state_t;

  typedef struct packed {
    mode_t      mode;
    motor_t     motor;
    msg_t       msg;
    logic [2:0] digits;
  } result_t;

endpackage

// File: rtl/tfcl_in_if.sv
// tfcl_in_if: valid/ready channel carrying one lock event item
// depends on tfcl_pkg for field widths
interface tfcl_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [tfcl_pkg::CharWidth-1:0] key_char;
  logic [tfcl_pkg::CodeWidth-1:0] factor_code;

  modport source (output valid, output operation, output key_char, output factor_code,
                  input ready);
  modport sink (input valid, input operation, input key_char, input factor_code,
                output ready);
endinterface

// File: rtl/tfcl_out_if.sv
// tfcl_out_if: valid/ready channel carrying one lock result item
// no package dependencies
interface tfcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] motor_command;
  logic [3:0] message;
  logic [2:0] digits_entered;

  modport source (output valid, output mode, output motor_command, output message,
                  output digits_entered, input ready);
  modport sink (input valid, input mode, input motor_command, input message,
                input digits_entered, output ready);
endinterface

// File: rtl/tfcl_core.sv
// tfcl_core: single-pass step of the lock state machine for one event item
// depends on tfcl_pkg; purely combinational, registers live in the top level
module tfcl_core (
  input  tfcl_pkg::state_t                cur,
  input  tfcl_pkg::item_t                 item,
  input  logic [tfcl_pkg::CodeWidth-1:0]  factor_cfg,
  output tfcl_pkg::state_t                nxt,
  output tfcl_pkg::result_t               res
);

  logic                                    key_ok;
  logic                                    kv;
  logic                                    full;
  logic [tfcl_pkg::CountWidth-1:0]         count_inc;
  logic [tfcl_pkg::CodeWidth-1:0]          entry_col;
  logic                                    fac_ok;
  logic                                    code_ok;
  logic                                    confirm_ok;
  logic                                    is_factor;
  logic                                    is_button;

  assign key_ok = item.key inside {[tfcl_pkg::KEY_0:tfcl_pkg::KEY_9],
                                   [tfcl_pkg::KEY_A:tfcl_pkg::KEY_D],
                                   tfcl_pkg::KEY_STAR, tfcl_pkg::KEY_HASH};
  assign kv        = (item.op == tfcl_pkg::OP_KEY) && key_ok;
  assign is_factor = (item.op == tfcl_pkg::OP_FACTOR);
  assign is_button = (item.op == tfcl_pkg::OP_BUTTON);
  assign full      = (cur.count == tfcl_pkg::COUNT_LAST);
  assign count_inc = cur.count + tfcl_pkg::CountWidth'(1);

  // place the key at the current entry position
  always_comb begin
    for (int b = 0; b < tfcl_pkg::CodeLength; b++) begin
      entry_col[b*tfcl_pkg::CharWidth +: tfcl_pkg::CharWidth] =
        (cur.count == tfcl_pkg::CountWidth'(b)) ? item.key
        : cur.entry[b*tfcl_pkg::CharWidth +: tfcl_pkg::CharWidth];
    end
  end

  assign fac_ok     = (item.factor == factor_cfg);
  assign code_ok    = (entry_col == cur.stored);
  assign confirm_ok = (entry_col == cur.pending);

  // next state
  always_comb begin
    nxt = cur;
    case (cur.mode)
      tfcl_pkg::MODE_ENTER: begin
        if (kv) begin
          nxt.entry = entry_col;
          if (full) begin
            nxt.count = '0;
            if (code_ok) nxt.mode = tfcl_pkg::MODE_FACTOR;
          end else begin
            nxt.count = count_inc;
          end
        end else if (is_button) begin
          nxt.mode  = tfcl_pkg::MODE_UNLOCKED;
          nxt.count = '0;
        end
      end
      tfcl_pkg::MODE_FACTOR: begin
        if (is_factor) begin
          nxt.mode  = fac_ok ? tfcl_pkg::MODE_UNLOCKED : tfcl_pkg::MODE_ENTER;
          nxt.count = '0;
        end
      end
      tfcl_pkg::MODE_UNLOCKED: begin
        if ((kv && item.key == tfcl_pkg::KEY_STAR) || is_button) begin
          nxt.mode  = tfcl_pkg::MODE_ENTER;
          nxt.count = '0;
        end else if (kv && item.key == tfcl_pkg::KEY_HASH) begin
          nxt.mode  = tfcl_pkg::MODE_FACTOR_CHG;
          nxt.count = '0;
        end
      end
      tfcl_pkg::MODE_FACTOR_CHG: begin
        if (is_factor) begin
          nxt.mode  = fac_ok ? tfcl_pkg::MODE_NEW : tfcl_pkg::MODE_UNLOCKED;
          nxt.count = '0;
        end
      end
      tfcl_pkg::MODE_NEW: begin
        if (kv) begin
          nxt.entry = entry_col;
          if (full) begin
            nxt.pending = entry_col;
            nxt.mode    = tfcl_pkg::MODE_CONFIRM;
            nxt.count   = '0;
          end else begin
            nxt.count = count_inc;
          end
        end
      end
      tfcl_pkg::MODE_CONFIRM: begin
        if (kv) begin
          nxt.entry = entry_col;
          if (full) begin
            nxt.count = '0;
            if (confirm_ok) begin
              nxt.stored = cur.pending;
              nxt.mode   = tfcl_pkg::MODE_UNLOCKED;
            end else begin
              nxt.mode = tfcl_pkg::MODE_NEW;
            end
          end else begin
            nxt.count = count_inc;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // result fields
  always_comb begin
    res.mode   = nxt.mode;
    res.digits = 3'(nxt.count);
    res.motor  = tfcl_pkg::MOTOR_NONE;
    res.msg    = tfcl_pkg::MSG_NONE;
    case (cur.mode)
      tfcl_pkg::MODE_ENTER: begin
        if (kv) begin
          if (full) res.msg = code_ok ? tfcl_pkg::MSG_USE_FACTOR : tfcl_pkg::MSG_WRONG_CODE;
        end else if (is_button) begin
          res.motor = tfcl_pkg::MOTOR_UNLOCK;
          res.msg   = tfcl_pkg::MSG_UNLOCKED;
        end
      end
      tfcl_pkg::MODE_FACTOR: begin
        if (is_factor) begin
          if (fac_ok) begin
            res.motor = tfcl_pkg::MOTOR_UNLOCK;
            res.msg   = tfcl_pkg::MSG_UNLOCKED;
          end else begin
            res.msg = tfcl_pkg::MSG_WRONG_CODE;
          end
        end
      end
      tfcl_pkg::MODE_UNLOCKED: begin
        if ((kv && item.key == tfcl_pkg::KEY_STAR) || is_button) begin
          res.motor = tfcl_pkg::MOTOR_LOCK;
          res.msg   = tfcl_pkg::MSG_ENTER_CODE;
        end else if (kv && item.key == tfcl_pkg::KEY_HASH) begin
          res.msg = tfcl_pkg::MSG_USE_FACTOR;
        end
      end
      tfcl_pkg::MODE_FACTOR_CHG: begin
        if (is_factor) res.msg = fac_ok ? tfcl_pkg::MSG_ENTER_NEW : tfcl_pkg::MSG_WRONG_CODE;
      end
      tfcl_pkg::MODE_NEW: begin
        if (kv && full) res.msg = tfcl_pkg::MSG_CONFIRM;
      end
      tfcl_pkg::MODE_CONFIRM: begin
        if (kv && full) res.msg = confirm_ok ? tfcl_pkg::MSG_CODE_SET : tfcl_pkg::MSG_MISMATCH;
      end
      default: begin
        res.msg = tfcl_pkg::MSG_NONE;
      end
    endcase
  end

endmodule

// File: rtl/two_factor_code_lock_controller.sv
// two_factor_code_lock_controller: top level with item register, lock state and result register
// depends on tfcl_pkg, tfcl_in_if, tfcl_out_if and tfcl_core
//
// Door-lock controller that takes one event item (key, second-factor code or inside button) per
// cycle while the result side keeps up and returns exactly one result item per event. An accepted
// item sits in an input register, passes the single-pass state machine in tfcl_core and lands in
// the result register; the decode and 32-bit code compares are combinational in tfcl_core. The
// second-factor code register is written through cfg_wr_en/cfg_wr_data and must only be changed
// while no item is in flight. No clearing pass is needed after reset.
module two_factor_code_lock_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  tfcl_in_if.sink                        in_ch,
  tfcl_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [tfcl_pkg::CodeWidth-1:0] cfg_wr_data
);

  logic                           s0_valid_r;
  tfcl_pkg::item_t                item_r;
  logic                           out_valid_r;
  tfcl_pkg::result_t              res_r;
  tfcl_pkg::result_t              res_nxt;
  tfcl_pkg::state_t               state_r;
  tfcl_pkg::state_t               state_nxt;
  logic [tfcl_pkg::CodeWidth-1:0] factor_cfg_r;
  logic                           advance;

  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || advance;

  tfcl_core u_core (
    .cur        (state_r),
    .item       (item_r),
    .factor_cfg (factor_cfg_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_cfg_r <= tfcl_pkg::FACTOR_CODE_RESET;
    end else if (cfg_wr_en) begin
      factor_cfg_r <= cfg_wr_data;
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op     <= in_ch.operation;
      item_r.key    <= in_ch.key_char;
      item_r.factor <= in_ch.factor_code;
    end
  end

  // lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode   <= tfcl_pkg::MODE_ENTER;
      state_r.count  <= '0;
      state_r.stored <= tfcl_pkg::STORED_CODE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mode           = res_r.mode;
  assign out_ch.motor_command  = res_r.motor;
  assign out_ch.message        = res_r.msg;
  assign out_ch.digits_entered = res_r.digits;

`ifndef NO_ASSERTIONS
  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item left the input register without reaching the result register");

  a_code_change_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(state_r.stored) |-> out_valid_r &&
      res_r.msg == tfcl_pkg::MSG_CODE_SET)
    else $error("stored code changed without a code set result");

  a_unlock_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.motor == tfcl_pkg::MOTOR_UNLOCK |->
      res_r.mode == tfcl_pkg::MODE_UNLOCKED && state_r.count == '0)
    else $error("unlock drive reported outside unlocked mode");
`endif

endmodule
